>>> rtl/tnd_pkg.sv
// ----------------------------------------------------------------------------
// tnd_pkg
// Shared types, constants and the period table of the tracker note decoder.
// ----------------------------------------------------------------------------
package tnd_pkg;

  localparam int unsigned HeldEntries    = 72;
  localparam int unsigned TableEntriesDef = 72;
  localparam int unsigned NotesPerOctave = 12;
  localparam logic [7:0]  KeyLastNote    = 8'd96;
  localparam logic [7:0]  KeyNoteOff     = 8'd97;
  localparam logic [7:0]  ToleranceReset = 8'd35;

  localparam logic [0:0]  RegFormatMode     = 1'd0;
  localparam logic [0:0]  RegMatchTolerance = 1'd1;

  typedef enum logic [1:0] {
    KIND_EMPTY   = 2'd0,
    KIND_NOTE    = 2'd1,
    KIND_OFF     = 2'd2,
    KIND_UNKNOWN = 2'd3
  } note_kind_e;

  typedef struct packed {
    logic        mode;
    logic [7:0]  key;
    logic        empty;
    logic [6:0]  best_idx;
    logic [11:0] best_diff;
  } match_rec_t;

  typedef struct packed {
    note_kind_e  kind;
    logic [3:0]  semitone;
    logic [2:0]  octave;
    logic [6:0]  note_number;
  } note_res_t;

  function automatic logic [11:0] period_at(logic [6:0] idx);
    logic [11:0] p;
    case (idx)
      7'd0:  p = 12'd856;  7'd1:  p = 12'd808;  7'd2:  p = 12'd762;
      7'd3:  p = 12'd720;  7'd4:  p = 12'd678;  7'd5:  p = 12'd640;
      7'd6:  p = 12'd604;  7'd7:  p = 12'd570;  7'd8:  p = 12'd538;
      7'd9:  p = 12'd508;  7'd10: p = 12'd480;  7'd11: p = 12'd453;
      7'd12: p = 12'd428;  7'd13: p = 12'd404;  7'd14: p = 12'd381;
      7'd15: p = 12'd360;  7'd16: p = 12'd339;  7'd17: p = 12'd320;
      7'd18: p = 12'd302;  7'd19: p = 12'd285;  7'd20: p = 12'd269;
      7'd21: p = 12'd254;  7'd22: p = 12'd240;  7'd23: p = 12'd226;
      7'd24: p = 12'd214;  7'd25: p = 12'd202;  7'd26: p = 12'd190;
      7'd27: p = 12'd180;  7'd28: p = 12'd170;  7'd29: p = 12'd160;
      7'd30: p = 12'd151;  7'd31: p = 12'd143;  7'd32: p = 12'd135;
      7'd33: p = 12'd127;  7'd34: p = 12'd120;  7'd35: p = 12'd113;
      7'd36: p = 12'd107;  7'd37: p = 12'd101;  7'd38: p = 12'd95;
      7'd39: p = 12'd90;   7'd40: p = 12'd85;   7'd41: p = 12'd80;
      7'd42: p = 12'd75;   7'd43: p = 12'd71;   7'd44: p = 12'd67;
      7'd45: p = 12'd64;   7'd46: p = 12'd60;   7'd47: p = 12'd57;
      7'd48: p = 12'd54;   7'd49: p = 12'd50;   7'd50: p = 12'd48;
      7'd51: p = 12'd45;   7'd52: p = 12'd42;   7'd53: p = 12'd40;
      7'd54: p = 12'd38;   7'd55: p = 12'd36;   7'd56: p = 12'd34;
      7'd57: p = 12'd32;   7'd58: p = 12'd30;   7'd59: p = 12'd28;
      7'd60: p = 12'd27;   7'd61: p = 12'd25;   7'd62: p = 12'd24;
      7'd63: p = 12'd22;   7'd64: p = 12'd21;   7'd65: p = 12'd20;
      7'd66: p = 12'd19;   7'd67: p = 12'd18;   7'd68: p = 12'd17;
      7'd69: p = 12'd16;   7'd70: p = 12'd15;   7'd71: p = 12'd14;
      default: p = 12'd0;
    endcase
    return p;
  endfunction

  // Octave by a reciprocal multiply, exact for values up to 95.
  function automatic logic [2:0] octave_of(logic [6:0] n);
    logic [12:0] prod;
    prod = 13'(n) * 13'd43;
    return prod[11:9];
  endfunction

endpackage

>>> rtl/tnd_in_if.sv
// ----------------------------------------------------------------------------
// tnd_in_if
// Input channel of the note decoder: one note per beat.
// ----------------------------------------------------------------------------
interface tnd_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] period;
  logic [7:0]  key;

  modport source (output valid, output period, output key, input ready);
  modport sink (input valid, input period, input key, output ready);
endinterface

>>> rtl/tnd_out_if.sv
// ----------------------------------------------------------------------------
// tnd_out_if
// Result channel of the note decoder: one decoded note per beat.
// ----------------------------------------------------------------------------
interface tnd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] note_kind;
  logic [3:0] semitone;
  logic [2:0] octave;
  logic [6:0] note_number;

  modport source (output valid, output note_kind, output semitone, output octave,
                  output note_number, input ready);
  modport sink (input valid, input note_kind, input semitone, input octave,
                input note_number, output ready);
endinterface

>>> rtl/tnd_result.sv
// ----------------------------------------------------------------------------
// tnd_result
// Final decode: tolerance check in period mode, key ranges in key mode, and
// the split of a note number into semitone and octave.
// ----------------------------------------------------------------------------
module tnd_result (
  input  tnd_pkg::match_rec_t rec_i,
  input  logic [7:0]          tolerance_i,
  output tnd_pkg::note_res_t  res_o
);

  logic [6:0] num;
  logic [2:0] oct;
  logic [6:0] oct_x12;
  logic [6:0] semi;
  logic       is_note;
  tnd_pkg::note_kind_e kind;

  always_comb begin
    if (rec_i.mode) begin
      num = 7'(rec_i.key - 8'd1);
      if (rec_i.key >= 8'd1 && rec_i.key <= tnd_pkg::KeyLastNote) begin
        kind = tnd_pkg::KIND_NOTE;
      end else if (rec_i.key == tnd_pkg::KeyNoteOff) begin
        kind = tnd_pkg::KIND_OFF;
      end else begin
        kind = tnd_pkg::KIND_EMPTY;
      end
    end else begin
      num = rec_i.best_idx;
      if (rec_i.empty) begin
        kind = tnd_pkg::KIND_EMPTY;
      end else if (rec_i.best_diff > {4'd0, tolerance_i}) begin
        kind = tnd_pkg::KIND_UNKNOWN;
      end else begin
        kind = tnd_pkg::KIND_NOTE;
      end
    end
  end

  assign is_note = (kind == tnd_pkg::KIND_NOTE);
  assign oct     = tnd_pkg::octave_of(num);
  assign oct_x12 = 7'({oct, 3'd0}) + 7'({oct, 2'd0});
  assign semi    = num - oct_x12;

  always_comb begin
    res_o.kind = kind;
    if (is_note) begin
      res_o.semitone    = semi[3:0];
      res_o.octave      = rec_i.mode ? oct : 3'(oct + 3'd1);
      res_o.note_number = num;
    end else begin
      res_o.semitone    = 4'd0;
      res_o.octave      = 3'd0;
      res_o.note_number = 7'd0;
    end
  end

endmodule

>>> rtl/tracker_note_decoder.sv
// ----------------------------------------------------------------------------
// tracker_note_decoder
// Decodes tracker notes from a period or a key into kind, semitone, octave.
// ----------------------------------------------------------------------------
// An accepted input beat passes four registered stages to a valid result.
// Throughput is one note per cycle while the output is ready; a stage holds
// its beat while the next stage stalls, so a stall loses or repeats nothing.
// Stages: table compares, boundary encode, nearest pick, final decode.
// Reset clears all stage valid bits, sets period mode and a tolerance of 35.
// ----------------------------------------------------------------------------
module tracker_note_decoder #(
  parameter int unsigned TABLE_ENTRIES = tnd_pkg::TableEntriesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  tnd_in_if.sink     note_in,
  tnd_out_if.source  note_out
);

  localparam int unsigned N0 = (TABLE_ENTRIES > tnd_pkg::HeldEntries) ?
                               tnd_pkg::HeldEntries : TABLE_ENTRIES;
  localparam int unsigned N  = (N0 < 1) ? 1 : N0;
  localparam int unsigned IW = $clog2(N + 1);

  logic       mode_q;
  logic [7:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      tol_q  <= tnd_pkg::ToleranceReset;
    end else if (cfg_we_i) begin
      if (cfg_index_i == tnd_pkg::RegFormatMode) begin
        mode_q <= cfg_data_i[0];
      end else if (cfg_index_i == tnd_pkg::RegMatchTolerance) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !s4_v_q || note_out.ready;
  assign rdy3 = !s3_v_q || rdy4;
  assign rdy2 = !s2_v_q || rdy3;
  assign rdy1 = !s1_v_q || rdy2;
  assign note_in.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= note_in.valid;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy3) s3_v_q <= s2_v_q;
      if (rdy4) s4_v_q <= s3_v_q;
    end
  end

  // Stage 1: compare the period against every table entry.
  logic [N-1:0] ge_d, s1_ge_q;
  logic [11:0]  s1_period_q;
  logic [7:0]   s1_key_q;
  logic         s1_mode_q;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ge_d[i] = (note_in.period >= tnd_pkg::period_at(7'(i)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && note_in.valid) begin
      s1_ge_q     <= ge_d;
      s1_period_q <= note_in.period;
      s1_key_q    <= note_in.key;
      s1_mode_q   <= mode_q;
    end
  end

  // Stage 2: the table is descending, so the compares form a thermometer code.
  logic [N-1:0]  first;
  logic [IW-1:0] k_d, s2_k_q;
  logic [11:0]   s2_period_q;
  logic [7:0]    s2_key_q;
  logic          s2_mode_q;

  always_comb begin
    first[0] = s1_ge_q[0];
    for (int i = 1; i < N; i++) begin
      first[i] = s1_ge_q[i] && !s1_ge_q[i-1];
    end
    k_d = (|s1_ge_q) ? '0 : IW'(N);
    for (int i = 0; i < N; i++) begin
      k_d = k_d | (first[i] ? IW'(i) : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_v_q) begin
      s2_k_q      <= k_d;
      s2_period_q <= s1_period_q;
      s2_key_q    <= s1_key_q;
      s2_mode_q   <= s1_mode_q;
    end
  end

  // Stage 3: pick the nearer of the two entries around the boundary.
  logic [IW-1:0] k_m1;
  logic [11:0]   t_lo, t_hi, d_lo, d_hi;
  logic          lo_ok, hi_ok, pick_lo;
  tnd_pkg::match_rec_t rec_d, s3_rec_q;

  assign k_m1    = s2_k_q - IW'(1);
  assign lo_ok   = (s2_k_q != '0);
  assign hi_ok   = (s2_k_q != IW'(N));
  assign t_lo    = tnd_pkg::period_at(7'(k_m1));
  assign t_hi    = tnd_pkg::period_at(7'(s2_k_q));
  assign d_lo    = t_lo - s2_period_q;
  assign d_hi    = s2_period_q - t_hi;
  assign pick_lo = lo_ok && (!hi_ok || (d_lo <= d_hi));

  always_comb begin
    rec_d.mode      = s2_mode_q;
    rec_d.key       = s2_key_q;
    rec_d.empty     = (s2_period_q == 12'd0);
    rec_d.best_idx  = pick_lo ? 7'(k_m1) : 7'(s2_k_q);
    rec_d.best_diff = pick_lo ? d_lo : d_hi;
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_v_q) begin
      s3_rec_q <= rec_d;
    end
  end

  // Stage 4: final decode into the output register.
  tnd_pkg::note_res_t res_d, s4_res_q;

  tnd_result u_result (
    .rec_i       (s3_rec_q),
    .tolerance_i (tol_q),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy4 && s3_v_q) begin
      s4_res_q <= res_d;
    end
  end

  assign note_out.valid       = s4_v_q;
  assign note_out.note_kind   = s4_res_q.kind;
  assign note_out.semitone    = s4_res_q.semitone;
  assign note_out.octave      = s4_res_q.octave;
  assign note_out.note_number = s4_res_q.note_number;

  a_boundary_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (s2_k_q <= IW'(N)))
    else $error("boundary index beyond table");

  a_pick_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_v_q && !s3_rec_q.mode) |-> (s3_rec_q.best_idx < 7'(N)))
    else $error("nearest entry beyond table");

  a_non_note_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_v_q && s4_res_q.kind != tnd_pkg::KIND_NOTE) |->
      (s4_res_q.semitone == 4'd0 && s4_res_q.octave == 3'd0 &&
       s4_res_q.note_number == 7'd0))
    else $error("non-note result carries note fields");

  a_semitone_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_v_q && s4_res_q.kind == tnd_pkg::KIND_NOTE) |-> (s4_res_q.semitone < 4'd12))
    else $error("semitone out of range");

endmodule

>>> bench/tnd_note_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tnd_note_checker
// Watches the configuration port and both note channels of the decoder,
// predicts every decoded note from the accepted input beat and the current
// register values, and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module tnd_note_checker #(
  parameter int unsigned TABLE_ENTRIES = tnd_pkg::TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  tnd_in_if           note_in,
  tnd_out_if          note_out,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import tnd_pkg::*;

  localparam logic [11:0] NotePeriods [72] = '{
    12'd856, 12'd808, 12'd762, 12'd720, 12'd678, 12'd640,
    12'd604, 12'd570, 12'd538, 12'd508, 12'd480, 12'd453,
    12'd428, 12'd404, 12'd381, 12'd360, 12'd339, 12'd320,
    12'd302, 12'd285, 12'd269, 12'd254, 12'd240, 12'd226,
    12'd214, 12'd202, 12'd190, 12'd180, 12'd170, 12'd160,
    12'd151, 12'd143, 12'd135, 12'd127, 12'd120, 12'd113,
    12'd107, 12'd101, 12'd95,  12'd90,  12'd85,  12'd80,
    12'd75,  12'd71,  12'd67,  12'd64,  12'd60,  12'd57,
    12'd54,  12'd50,  12'd48,  12'd45,  12'd42,  12'd40,
    12'd38,  12'd36,  12'd34,  12'd32,  12'd30,  12'd28,
    12'd27,  12'd25,  12'd24,  12'd22,  12'd21,  12'd20,
    12'd19,  12'd18,  12'd17,  12'd16,  12'd15,  12'd14
  };

  logic        key_mode_q;
  logic [7:0]  tolerance_q;
  note_res_t   note_q [$];
  int unsigned fails;

  function automatic note_res_t decode_note(logic key_mode, logic [7:0] tolerance,
                                            logic [11:0] period, logic [7:0] key);
    note_res_t   r;
    int unsigned entries;
    int unsigned best;
    int unsigned best_diff;
    int unsigned d;
    int unsigned n;
    r.kind        = KIND_EMPTY;
    r.semitone    = '0;
    r.octave      = '0;
    r.note_number = '0;
    entries = TABLE_ENTRIES;
    if (entries > HeldEntries) entries = HeldEntries;
    if (entries < 1) entries = 1;
    if (!key_mode) begin
      if (period != 12'd0) begin
        best      = 0;
        best_diff = 32'hFFFF_FFFF;
        for (int unsigned i = 0; i < entries; i++) begin
          d = (period >= NotePeriods[i]) ? period - NotePeriods[i] : NotePeriods[i] - period;
          if (d < best_diff) begin
            best_diff = d;
            best      = i;
          end
        end
        if (best_diff > tolerance) begin
          r.kind = KIND_UNKNOWN;
        end else begin
          r.kind        = KIND_NOTE;
          r.semitone    = 4'(best % NotesPerOctave);
          r.octave      = 3'(best / NotesPerOctave + 1);
          r.note_number = 7'(best);
        end
      end
    end else if (key >= 8'd1 && key <= KeyLastNote) begin
      n             = key - 1;
      r.kind        = KIND_NOTE;
      r.semitone    = 4'(n % NotesPerOctave);
      r.octave      = 3'(n / NotesPerOctave);
      r.note_number = 7'(n);
    end else if (key == KeyNoteOff) begin
      r.kind = KIND_OFF;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    note_res_t want;
    if (!rst_ni) begin
      key_mode_q   <= 1'b0;
      tolerance_q  <= ToleranceReset;
      note_q.delete();
      fails        = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegFormatMode) begin
          key_mode_q <= cfg_data_i[0];
        end else if (cfg_index_i == RegMatchTolerance) begin
          tolerance_q <= cfg_data_i;
        end
      end
      if (note_in.valid && note_in.ready) begin
        note_q.push_back(decode_note(key_mode_q, tolerance_q, note_in.period, note_in.key));
      end
      if (note_out.valid && note_out.ready) begin
        if (note_q.size() == 0) begin
          $display("%0t: result beat with none expected, got kind %0d semitone %0d octave %0d note %0d",
                   $time, note_out.note_kind, note_out.semitone, note_out.octave,
                   note_out.note_number);
          fails++;
        end else begin
          want = note_q.pop_front();
          if (note_out.note_kind !== want.kind) begin
            $display("%0t: note_kind expected %0d got %0d", $time, want.kind, note_out.note_kind);
            fails++;
          end
          if (note_out.semitone !== want.semitone) begin
            $display("%0t: semitone expected %0d got %0d", $time, want.semitone,
                     note_out.semitone);
            fails++;
          end
          if (note_out.octave !== want.octave) begin
            $display("%0t: octave expected %0d got %0d", $time, want.octave, note_out.octave);
            fails++;
          end
          if (note_out.note_number !== want.note_number) begin
            $display("%0t: note_number expected %0d got %0d", $time, want.note_number,
                     note_out.note_number);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= note_q.size();
    end
  end

endmodule

>>> bench/tracker_note_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tracker_note_decoder_test
// Drives notes into the decoder in period and key mode under several register
// settings, with random gaps on both channels, and takes the verdict from the
// checker that runs beside the block.
// ----------------------------------------------------------------------------
module tracker_note_decoder_test;
  import tnd_pkg::*;

  localparam int unsigned Entries   = TableEntriesDef;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned PhaseNotes = 185;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        in_idle_en;
  logic        out_idle_en;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;

  tnd_in_if  note_in ();
  tnd_out_if note_out ();

  tracker_note_decoder #(
    .TABLE_ENTRIES(Entries)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .note_in    (note_in),
    .note_out   (note_out)
  );

  tnd_note_checker #(
    .TABLE_ENTRIES(Entries)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .note_in     (note_in),
    .note_out    (note_out),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    note_out.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      int unsigned gap;
      gap = out_idle_en ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        note_out.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      note_out.ready <= 1'b1;
      @(posedge clk_i);
      while (!(note_out.valid && note_out.ready)) @(posedge clk_i);
    end
  end

  task automatic send_note(logic [11:0] period, logic [7:0] key);
    int unsigned gap;
    gap = in_idle_en ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      note_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    note_in.valid  <= 1'b1;
    note_in.period <= period;
    note_in.key    <= key;
    @(posedge clk_i);
    while (!(note_in.valid && note_in.ready)) @(posedge clk_i);
  endtask

  task automatic drain_notes();
    note_in.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_config(logic key_mode, logic [7:0] tolerance);
    logic [6:0] junk;
    junk = 7'($urandom);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= RegFormatMode;
    cfg_data_i  <= {junk, key_mode};
    @(posedge clk_i);
    cfg_index_i <= RegMatchTolerance;
    cfg_data_i  <= tolerance;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_random_note(logic key_mode);
    int unsigned pick;
    int unsigned idx;
    int          p;
    int          span;
    logic [11:0] period;
    logic [7:0]  key;
    pick   = $urandom_range(0, 9);
    period = 12'($urandom);
    key    = 8'($urandom);
    if (!key_mode) begin
      idx = $urandom_range(0, HeldEntries - 2);
      if (pick == 0) begin
        period = 12'd0;
      end else if (pick == 3) begin
        period = 12'((period_at(7'(idx)) + period_at(7'(idx + 1))) / 2);
      end else if (pick >= 4) begin
        span = $urandom_range(0, 40);
        p    = int'(period_at(7'(idx))) + int'($urandom_range(0, 2 * span)) - span;
        if (p < 0) p = 0;
        period = 12'(p);
      end
    end else begin
      if (pick <= 6) begin
        key = 8'($urandom_range(1, 97));
      end else if (pick == 7) begin
        key = ($urandom_range(0, 1) != 0) ? KeyNoteOff : 8'd0;
      end
    end
    send_note(period, key);
  endtask

  initial begin
    logic        key_mode;
    logic [7:0]  tolerance;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= RegFormatMode;
    cfg_data_i     <= 8'd0;
    note_in.valid  <= 1'b0;
    note_in.period <= 12'd0;
    note_in.key    <= 8'd0;
    in_idle_en     = 1'b1;
    out_idle_en    = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: period mode with the default tolerance.
    send_note(12'd0, 8'($urandom));
    send_note(12'd4095, 8'($urandom));
    send_note(12'd856, 8'($urandom));
    send_note(12'd14, 8'($urandom));
    send_note(12'd1, 8'($urandom));
    send_note(12'd891, 8'($urandom));
    send_note(12'd892, 8'($urandom));
    send_note(12'd785, 8'($urandom));
    drain_notes();

    set_config(1'b0, 8'd255);
    send_note(12'd1111, 8'($urandom));
    send_note(12'd1112, 8'($urandom));
    send_note(12'd4095, 8'($urandom));
    drain_notes();

    set_config(1'b0, 8'd0);
    send_note(12'd857, 8'($urandom));
    send_note(12'd856, 8'($urandom));
    send_note(12'd785, 8'($urandom));
    send_note(12'd14, 8'($urandom));
    drain_notes();

    set_config(1'b1, 8'($urandom));
    send_note(12'($urandom), 8'd0);
    send_note(12'($urandom), 8'd1);
    send_note(12'($urandom), 8'd12);
    send_note(12'($urandom), 8'd13);
    send_note(12'($urandom), 8'd96);
    send_note(12'($urandom), KeyNoteOff);
    send_note(12'($urandom), 8'd98);
    send_note(12'($urandom), 8'd255);
    drain_notes();

    for (int unsigned ph = 0; ph < 8; ph++) begin
      key_mode = ph[0];
      case ((ph / 2) % 4)
        0:       tolerance = ToleranceReset;
        1:       tolerance = 8'd0;
        2:       tolerance = 8'd255;
        default: tolerance = 8'($urandom);
      endcase
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      set_config(key_mode, tolerance);
      repeat (PhaseNotes) send_random_note(key_mode);
      drain_notes();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tnd_pkg.sv
rtl/tnd_in_if.sv
rtl/tnd_out_if.sv
rtl/tnd_result.sv
rtl/tracker_note_decoder.sv
bench/tnd_note_checker.sv
bench/tracker_note_decoder_test.sv
